// ----- hdl/ism_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval sort and merge package
// Shared sizes, payload types and controller states of the interval sort and
// merge core.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int VAL_W         = 32;
  localparam int COUNT_W       = 6;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t s_val;
    val_t e_val;
  } span_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_COUNT,
    ST_EMIT,
    ST_FLUSH
  } state_t;

endpackage

// ----- hdl/ism_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read and read enable.
// ----------------------------------------------------------------------------
module ism_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/interval_sort_and_merge_core.sv -----
// ----------------------------------------------------------------------------
// Interval sort and merge core
// Loads closed intervals into one RAM until an item marked final, sorts them
// by start with a selection sort over the RAM and emits the merged intervals.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall   | range_start, range_end, final
//   out_    | output    | out_valid/out_stall | merged start/end, count, flags
//
// While loading, a non-final item is taken without a stall. After a final item
// the sort scans the stored intervals for each position in turn, passing through
// ST_SWAP_A and ST_SWAP_B when a swap is needed, and then makes the two merge
// passes (count, then emit); the run time is set by the single RAM read port.
// Reset clears the controller only; the RAM needs no clearing pass.
// Stalls on the output freeze the emit pass; the input stalls from a final
// item until the last merged item is in the output register.
// ----------------------------------------------------------------------------
module interval_sort_and_merge_core import ism_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_range_start,
  input  logic signed [31:0] in_range_end,
  input  logic               in_final_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_merged_start,
  output logic signed [31:0] out_merged_end,
  output logic [5:0]         out_merged_count,
  output logic               out_overflowed,
  output logic               out_end_of_run
);

  localparam int SPAN_W = $bits(span_t);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  span_t             cur_r, cur_nxt;
  span_t             best_r, best_nxt;
  logic [CNT_W-1:0]  runs_r, runs_nxt;
  val_t              run_s_r, run_s_nxt;
  val_t              run_e_r, run_e_nxt;

  logic              out_valid_r;
  val_t              out_s_r, out_e_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic              out_ovf_r, out_last_r;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [SPAN_W-1:0] ram_wdata, ram_rdata;
  span_t             rd;

  logic [CNT_W-1:0]  prev_j;
  logic [IDX_W-1:0]  prev_idx;
  logic [CNT_W-1:0]  n_after;
  logic              can_load, step_ok, go_next, at_tail;
  logic              emit_en, emit_last;
  val_t              emit_s, emit_e;

  ism_ram #(
    .WIDTH (SPAN_W),
    .DEPTH (MAX_INTERVALS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = span_t'(ram_rdata);
  assign prev_j    = j_r - CNT_W'(1);
  assign prev_idx  = prev_j[IDX_W-1:0];
  assign can_load  = !out_valid_r || !out_stall;
  assign at_tail   = (CNT_W'(i_r) + CNT_W'(2)) == fill_r;
  assign ram_raddr = j_r[IDX_W-1:0];
  assign in_stall  = (state_r != ST_LOAD);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    j_nxt        = j_r;
    pend_nxt     = pend_r;
    i_nxt        = i_r;
    best_idx_nxt = best_idx_r;
    cur_nxt      = cur_r;
    best_nxt     = best_r;
    runs_nxt     = runs_r;
    run_s_nxt    = run_s_r;
    run_e_nxt    = run_e_r;
    ram_we       = 1'b0;
    ram_waddr    = i_r;
    ram_wdata    = cur_r;
    ram_re       = 1'b0;
    n_after      = fill_r;
    step_ok      = 1'b0;
    go_next      = 1'b0;
    emit_en      = 1'b0;
    emit_last    = 1'b0;
    emit_s       = run_s_r;
    emit_e       = run_e_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (fill_r < CNT_W'(MAX_INTERVALS)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[IDX_W-1:0];
            ram_wdata = span_t'{s_val: in_range_start, e_val: in_range_end};
            fill_nxt  = fill_r + CNT_W'(1);
            n_after   = fill_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_item) begin
            j_nxt    = '0;
            pend_nxt = 1'b0;
            i_nxt    = '0;
            runs_nxt = '0;
            state_nxt = (n_after == CNT_W'(1)) ? ST_COUNT : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (j_r != fill_r) begin
          ram_re = 1'b1;
          j_nxt  = j_r + CNT_W'(1);
        end
        pend_nxt = (j_r != fill_r);
        if (pend_r) begin
          if (prev_idx == i_r) begin
            cur_nxt      = rd;
            best_nxt     = rd;
            best_idx_nxt = i_r;
          end else if ($signed(rd.s_val) < $signed(best_r.s_val)) begin
            best_nxt     = rd;
            best_idx_nxt = prev_idx;
          end
          if (j_r == fill_r) begin
            if (best_idx_nxt == i_r) begin
              go_next = 1'b1;
            end else begin
              state_nxt = ST_SWAP_A;
            end
          end
        end
      end

      ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_r;
        ram_wdata = cur_r;
        state_nxt = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = best_r;
        go_next   = 1'b1;
      end

      ST_COUNT, ST_EMIT: begin
        step_ok = (state_r == ST_COUNT) || can_load;
        if (step_ok) begin
          if (j_r != fill_r) begin
            ram_re = 1'b1;
            j_nxt  = j_r + CNT_W'(1);
          end
          pend_nxt = (j_r != fill_r);
          if (pend_r) begin
            if (prev_j == '0) begin
              run_s_nxt = rd.s_val;
              run_e_nxt = rd.e_val;
            end else if ($signed(run_e_r) < $signed(rd.s_val)) begin
              if (state_r == ST_COUNT) begin
                runs_nxt = runs_r + CNT_W'(1);
              end else begin
                emit_en = 1'b1;
              end
              run_s_nxt = rd.s_val;
              run_e_nxt = rd.e_val;
            end else if ($signed(run_e_r) < $signed(rd.e_val)) begin
              run_e_nxt = rd.e_val;
            end
            if (j_r == fill_r) begin
              if (state_r == ST_COUNT) begin
                runs_nxt  = runs_nxt + CNT_W'(1);
                j_nxt     = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
          end
        end
      end

      ST_FLUSH: begin
        if (can_load) begin
          emit_en   = 1'b1;
          emit_last = 1'b1;
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (go_next) begin
      i_nxt    = i_r + IDX_W'(1);
      j_nxt    = CNT_W'(i_r) + CNT_W'(1);
      pend_nxt = 1'b0;
      if (at_tail) begin
        j_nxt     = '0;
        runs_nxt  = '0;
        state_nxt = ST_COUNT;
      end else begin
        state_nxt = ST_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    best_idx_r <= best_idx_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    runs_r     <= runs_nxt;
    run_s_r    <= run_s_nxt;
    run_e_r    <= run_e_nxt;
    if (emit_en) begin
      out_s_r    <= emit_s;
      out_e_r    <= emit_e;
      out_cnt_r  <= COUNT_W'(runs_r);
      out_ovf_r  <= ovf_r;
      out_last_r <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_start = out_s_r;
  assign out_merged_end   = out_e_r;
  assign out_merged_count = out_cnt_r;
  assign out_overflowed   = out_ovf_r;
  assign out_end_of_run   = out_last_r;

endmodule

// ----- hdl/ism_checker.sv -----
// ----------------------------------------------------------------------------
// Interval sort and merge port checker
// Watches the ports of the core for handshake and sequencing rules.
// ----------------------------------------------------------------------------
module ism_checker import ism_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_final_item,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_merged_start,
  input logic signed [31:0] out_merged_end,
  input logic [5:0]         out_merged_count,
  input logic               out_overflowed,
  input logic               out_end_of_run
);

  // A stalled result item holds its place and its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_merged_start) &&
      $stable(out_merged_end) && $stable(out_merged_count) &&
      $stable(out_overflowed) && $stable(out_end_of_run))
    else $error("stalled result item changed");

  // Every set yields at least one merged interval.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_merged_count != COUNT_W'(0))
    else $error("result item with zero count");

  // A final item ends loading, so the input stalls in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_item |=> in_stall)
    else $error("input not stalled after final item");

  // While loading, a non-final item keeps the input open.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_final_item |=> !in_stall)
    else $error("input stalled during load");

endmodule

bind interval_sort_and_merge_core ism_checker u_ism_checker (.*);
